/* rtl/gha_pkg.sv */
// Shared types and codes for the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 8;
	localparam int VER_W    = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_CREATE = 3'd0,
		REQ_FREE   = 3'd1,
		REQ_QUERY  = 3'd2,
		REQ_CLEAR  = 3'd3,
		REQ_SCAN   = 3'd4
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_REJECT    = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ISSUE = 7'b0000010,
		S_POP   = 7'b0000100,
		S_BUMP  = 7'b0001000,
		S_CHECK = 7'b0010000,
		S_SCAN  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

/* rtl/generational_handle_allocator.sv */
// Top level of the generational handle allocator: version table, free-slot stack and sequencer.
`timescale 1ns / 1ps

// Hands out handles made of a slot index and a version; an odd version marks a live slot.
// One request word is taken at a time and gives one result word. The version table and the
// free-slot stack are simple dual-port synchronous memories with a registered read, and their
// dependent reads set the path through the states: clear and create of a new slot go from
// issue to done, free and query go through check (straight to done when the index is past
// the open count), create that reuses a freed slot goes through pop and bump (stack read,
// then version read), and scan walks the slots it examines, one version read per cycle.
// A result in the output register does not block the next request, whose result waits in S_DONE.
// Slots past the open count hold stale data after clear and are never read.
module generational_handle_allocator
	import gha_pkg::*;
#(
	parameter int SLOT_COUNT   = 256,
	parameter int VERSION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [23:0]               s_axis_tdata,  // handle_index, handle_version
	input  logic [REQ_W-1:0]          s_axis_tuser,  // req_type
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [23:0]               m_axis_tdata,  // result_index, result_version
	output logic [STATUS_W-1:0]       m_axis_tuser   // status
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam int VW = VERSION_BITS;
	localparam logic [CW-1:0] SLOTS_MAX = CW'(SLOT_COUNT);
	localparam logic [VW-1:0] VER_ONE   = {{(VW-1){1'b0}}, 1'b1};
	localparam logic [VW-1:0] VER_LIM   = {{(VW-1){1'b1}}, 1'b0};

	logic [VW-1:0] ver_mem [SLOT_COUNT];
	logic [IW-1:0] stk_mem [SLOT_COUNT];

	state_t              state_q, state_d;
	logic [CW-1:0]       slots_used_q, slots_used_d;
	logic [CW-1:0]       free_count_q, free_count_d;
	logic                m_valid_q;
	logic [REQ_W-1:0]    req_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [VW-1:0]       ver_q;
	logic [IW-1:0]       slot_q, slot_d;
	status_t             res_status_q, res_status_d;
	logic [INDEX_W-1:0]  res_index_q, res_index_d;
	logic [VER_W-1:0]    res_version_q, res_version_d;
	logic [STATUS_W-1:0] out_status_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic [VER_W-1:0]    out_version_q;

	logic [VW-1:0] ver_rd_q;
	logic [IW-1:0] stk_rd_q;
	logic          ver_we, stk_we;
	logic [IW-1:0] ver_waddr, ver_raddr, stk_waddr, stk_raddr, stk_wdata;
	logic [VW-1:0] ver_wdata;

	logic          in_accept, out_load, live;
	logic [CW-1:0] fc_m1, scan_nxt;
	logic [VW-1:0] ver_inc;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_version_q, out_index_q};
	assign m_axis_tuser  = out_status_q;

	assign fc_m1    = free_count_q - CW'(1);
	assign scan_nxt = CW'(slot_q) + CW'(1);
	assign ver_inc  = ver_rd_q + VER_ONE;
	assign live     = ver_rd_q[0] && (ver_rd_q == ver_q);

	always_comb begin
		state_d       = state_q;
		slots_used_d  = slots_used_q;
		free_count_d  = free_count_q;
		slot_d        = slot_q;
		res_status_d  = res_status_q;
		res_index_d   = res_index_q;
		res_version_d = res_version_q;
		ver_we        = 1'b0;
		ver_waddr     = slot_q;
		ver_wdata     = ver_inc;
		ver_raddr     = slot_q;
		stk_we        = 1'b0;
		stk_waddr     = IW'(free_count_q);
		stk_wdata     = IW'(idx_q);
		stk_raddr     = IW'(fc_m1);
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				res_status_d  = STAT_REJECT;
				res_index_d   = '0;
				res_version_d = '0;
				state_d       = S_DONE;
				case (req_q)
					REQ_CREATE: begin
						if (free_count_q != '0) begin
							free_count_d = fc_m1;
							state_d      = S_POP;
						end else if (slots_used_q == SLOTS_MAX) begin
							res_status_d = STAT_FULL;
						end else begin
							ver_we        = 1'b1;
							ver_waddr     = IW'(slots_used_q);
							ver_wdata     = VER_ONE;
							slots_used_d  = slots_used_q + CW'(1);
							res_status_d  = STAT_OK;
							res_index_d   = INDEX_W'(slots_used_q);
							res_version_d = VER_W'(VER_ONE);
						end
					end
					REQ_FREE, REQ_QUERY: begin
						if (XW'(idx_q) < XW'(slots_used_q)) begin
							ver_raddr = IW'(idx_q);
							slot_d    = IW'(idx_q);
							state_d   = S_CHECK;
						end
					end
					REQ_CLEAR: begin
						slots_used_d = '0;
						free_count_d = '0;
						res_status_d = STAT_OK;
					end
					REQ_SCAN: begin
						if (XW'(idx_q) < XW'(slots_used_q)) begin
							ver_raddr = IW'(idx_q);
							slot_d    = IW'(idx_q);
							state_d   = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_POP: begin
				slot_d    = stk_rd_q;
				ver_raddr = stk_rd_q;
				state_d   = S_BUMP;
			end
			S_BUMP: begin
				state_d = S_DONE;
				if (ver_rd_q >= VER_LIM) begin
					res_status_d = STAT_EXHAUSTED;
				end else begin
					ver_we        = 1'b1;
					res_status_d  = STAT_OK;
					res_index_d   = INDEX_W'(slot_q);
					res_version_d = VER_W'(ver_inc);
				end
			end
			S_CHECK: begin
				state_d = S_DONE;
				if (live) begin
					res_status_d = STAT_OK;
					if (req_q == REQ_FREE) begin
						ver_we = 1'b1;
						if (free_count_q != SLOTS_MAX) begin
							stk_we       = 1'b1;
							free_count_d = free_count_q + CW'(1);
						end
					end
				end
			end
			S_SCAN: begin
				if (ver_rd_q[0]) begin
					res_status_d  = STAT_OK;
					res_index_d   = INDEX_W'(slot_q);
					res_version_d = VER_W'(ver_rd_q);
					state_d       = S_DONE;
				end else if (scan_nxt >= slots_used_q) begin
					state_d = S_DONE;
				end else begin
					ver_raddr = IW'(scan_nxt);
					slot_d    = IW'(scan_nxt);
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slots_used_q <= '0;
			free_count_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			slots_used_q <= slots_used_d;
			free_count_q <= free_count_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q <= s_axis_tuser;
			idx_q <= s_axis_tdata[7:0];
			ver_q <= VW'(s_axis_tdata[23:8]);
		end
		slot_q        <= slot_d;
		res_status_q  <= res_status_d;
		res_index_q   <= res_index_d;
		res_version_q <= res_version_d;
		if (out_load) begin
			out_status_q  <= res_status_q;
			out_index_q   <= res_index_q;
			out_version_q <= res_version_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ver_we) begin
			ver_mem[ver_waddr] <= ver_wdata;
		end
		ver_rd_q <= ver_mem[ver_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

endmodule

/* dv/generational_handle_allocator_tb.sv */
// Generational handle allocator bench: directed, table-full, backpressure, slot-reuse, random traffic.
`timescale 1ns / 1ps

module generational_handle_allocator_tb;
	import gha_pkg::*;

	localparam int SLOTS = 1 << INDEX_W;
	localparam logic [VER_W-1:0] VER_INVALID = '1;
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
	localparam int PHASE_ITEMS = 270;
	localparam int REUSE_ROUNDS = 32;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 300;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct packed {
		status_t              st;
		logic [INDEX_W-1:0]   idx;
		logic [VER_W-1:0]     ver;
	} reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [23:0]         s_axis_tdata = '0;   // handle_index, handle_version
	logic [REQ_W-1:0]    s_axis_tuser = '0;   // req_type
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [23:0]         m_axis_tdata;        // result_index, result_version
	logic [STATUS_W-1:0] m_axis_tuser;        // status

	// predicted allocator state
	logic [VER_W-1:0]   slot_version [SLOTS];
	logic [INDEX_W-1:0] free_slot_stack [SLOTS];
	int                 free_depth = 0;
	int                 open_count = 0;

	reply_t due_replies [$];
	int     errors = 0;
	int     cycle_count = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     hold_seq = 0;
	int     hold_seen = 0;
	int     hold_left = 0;

	generational_handle_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic bit handle_live(input logic [INDEX_W-1:0] idx, input logic [VER_W-1:0] ver);
		return (int'(idx) < open_count) && slot_version[idx][0] && (slot_version[idx] == ver);
	endfunction

	function automatic reply_t predict_reply(input logic [REQ_W-1:0] req,
			input logic [INDEX_W-1:0] idx, input logic [VER_W-1:0] ver);
		reply_t r;
		int     s;
		r = '{STAT_REJECT, '0, '0};
		case (req)
		REQ_CREATE: begin
			if (free_depth > 0) begin
				free_depth--;
				s = int'(free_slot_stack[free_depth]);
				if (slot_version[s] >= VER_INVALID - 1) begin
					r.st = STAT_EXHAUSTED;
				end else begin
					slot_version[s] = slot_version[s] + 1'b1;
					r = '{STAT_OK, s[INDEX_W-1:0], slot_version[s]};
				end
			end else if (open_count >= SLOTS) begin
				r.st = STAT_FULL;
			end else begin
				s = open_count;
				slot_version[s] = VER_W'(1);
				open_count++;
				r = '{STAT_OK, s[INDEX_W-1:0], slot_version[s]};
			end
		end
		REQ_FREE: begin
			if (handle_live(idx, ver)) begin
				slot_version[idx] = slot_version[idx] + 1'b1;
				if (free_depth < SLOTS) begin
					free_slot_stack[free_depth] = idx;
					free_depth++;
				end
				r.st = STAT_OK;
			end
		end
		REQ_QUERY: begin
			if (handle_live(idx, ver))
				r.st = STAT_OK;
		end
		REQ_CLEAR: begin
			open_count = 0;
			free_depth = 0;
			r.st = STAT_OK;
		end
		REQ_SCAN: begin
			for (s = int'(idx); s < open_count; s++) begin
				if (slot_version[s][0]) begin
					r = '{STAT_OK, s[INDEX_W-1:0], slot_version[s]};
					break;
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// one request word; tvalid stays high into the next call unless a gap is taken
	task automatic send_req(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] idx,
			input logic [VER_W-1:0] ver, output reply_t predicted);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ver, idx};
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		predicted = predict_reply(req, idx, ver);
		due_replies = {due_replies, predicted};
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (due_replies.size() != 0);
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_replies.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual status %0d index %0d version %0d",
					$time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8]);
				errors++;
			end else begin
				want = due_replies.pop_front();
				if (m_axis_tuser !== want.st) begin
					$display("%0t: status: expected %0d, actual %0d", $time, want.st, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[7:0] !== want.idx) begin
					$display("%0t: result_index: expected %0d, actual %0d",
						$time, want.idx, m_axis_tdata[7:0]);
					errors++;
				end
				if (m_axis_tdata[23:8] !== want.ver) begin
					$display("%0t: result_version: expected %h, actual %h",
						$time, want.ver, m_axis_tdata[23:8]);
					errors++;
				end
			end
		end
	end

	function automatic bit find_live(output int slot);
		int k;
		int base;
		slot = 0;
		if (open_count == 0)
			return 0;
		repeat (8) begin
			k = $urandom_range(open_count - 1);
			if (slot_version[k][0]) begin
				slot = k;
				return 1;
			end
		end
		base = $urandom_range(open_count - 1);
		for (k = 0; k < open_count; k++) begin
			if (slot_version[(base + k) % open_count][0]) begin
				slot = (base + k) % open_count;
				return 1;
			end
		end
		return 0;
	endfunction

	task automatic random_item();
		int                 pick;
		int                 slot;
		logic [REQ_W-1:0]   req;
		logic [INDEX_W-1:0] idx;
		logic [VER_W-1:0]   ver;
		reply_t             r;
		pick = $urandom_range(99);
		req = REQ_CREATE;
		idx = INDEX_W'($urandom_range(SLOTS - 1));
		ver = VER_W'($urandom_range(65535));
		if (pick < 30) begin
			req = REQ_CREATE;
		end else if (pick < 65) begin
			if (find_live(slot)) begin
				req = (pick < 55) ? REQ_FREE : REQ_QUERY;
				idx = INDEX_W'(slot);
				ver = slot_version[slot];
			end
		end else if (pick < 73) begin
			req = $urandom_range(1) ? REQ_FREE : REQ_QUERY;
		end else if (pick < 80) begin
			// stale handle: previous generation of an opened slot
			if (open_count > 0) begin
				idx = INDEX_W'($urandom_range(open_count - 1));
				ver = slot_version[idx] - 1'b1;
			end
			req = $urandom_range(1) ? REQ_FREE : REQ_QUERY;
		end else if (pick < 95) begin
			req = REQ_SCAN;
			if ($urandom_range(3) != 0)
				idx = INDEX_W'($urandom_range(open_count));
		end else if (pick < 97) begin
			req = REQ_CLEAR;
		end else begin
			req = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
		end
		send_req(req, idx, ver, r);
	endtask

	task automatic test_directed();
		reply_t r;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_req(REQ_QUERY, 8'd0, 16'd1, r);
		send_req(REQ_SCAN, 8'd0, 16'd0, r);
		send_req(REQ_FREE, 8'd0, 16'd1, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_QUERY, 8'd1, 16'd1, r);
		send_req(REQ_QUERY, 8'd1, 16'd2, r);
		send_req(REQ_FREE, 8'd1, 16'd1, r);
		send_req(REQ_QUERY, 8'd1, 16'd2, r);
		send_req(REQ_FREE, 8'd1, 16'd2, r);
		send_req(REQ_SCAN, 8'd1, 16'd0, r);
		send_req(REQ_SCAN, 8'd255, 16'hFFFF, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_FREE, 8'd0, 16'd1, r);
		send_req(REQ_FREE, 8'd2, 16'd1, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		for (int c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI; c++)
			send_req(c[REQ_W-1:0], 8'd255, 16'hFFFF, r);
		send_req(REQ_QUERY, 8'd255, 16'hFFFF, r);
		send_req(REQ_SCAN, 8'd0, 16'd0, r);
		send_req(REQ_CLEAR, 8'd0, 16'd0, r);
		send_req(REQ_QUERY, 8'd1, 16'd3, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		wait_drained();
	endtask

	task automatic test_table_full();
		reply_t r;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_req(REQ_CLEAR, 8'd0, 16'd0, r);
		repeat (SLOTS) send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_FREE, 8'd100, 16'd1, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		// retire everything but the top slot, then scan the whole table
		for (int k = 0; k < SLOTS - 1; k++)
			send_req(REQ_FREE, k[INDEX_W-1:0], slot_version[k], r);
		send_req(REQ_SCAN, 8'd0, 16'd0, r);
		send_req(REQ_QUERY, 8'd255, slot_version[SLOTS-1], r);
		repeat (8) send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_CLEAR, 8'd0, 16'd0, r);
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_seq++;
		repeat (48) random_item();
		wait_drained();
	endtask

	task automatic test_slot_reuse();
		reply_t r;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_req(REQ_CLEAR, 8'd0, 16'd0, r);
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		repeat (REUSE_ROUNDS) begin
			send_req(REQ_FREE, 8'd0, slot_version[0], r);
			send_req(REQ_CREATE, 8'd0, 16'd0, r);
		end
		send_req(REQ_CREATE, 8'd0, 16'd0, r);
		send_req(REQ_QUERY, 8'd0, slot_version[0], r);
		send_req(REQ_FREE, 8'd0, slot_version[0], r);
		send_req(REQ_SCAN, 8'd0, 16'd0, r);
		send_req(REQ_CLEAR, 8'd0, 16'd0, r);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (PHASE_ITEMS) random_item();
		send_idle_pct = 78;
		repeat (PHASE_ITEMS) random_item();
		send_idle_pct = 0;
		recv_stall_pct = 78;
		repeat (PHASE_ITEMS) random_item();
		send_idle_pct = 32;
		recv_stall_pct = 32;
		repeat (PHASE_ITEMS) random_item();
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_slot_reuse();
		test_random_traffic();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
rtl/gha_pkg.sv
rtl/generational_handle_allocator.sv
dv/generational_handle_allocator_tb.sv
